/* rtl/core/newton_divided_difference_interp_assert.svh */
// Assertion macros for the Newton interpolation core.
`ifndef NEWTON_DIVIDED_DIFFERENCE_INTERP_ASSERT_SVH
`define NEWTON_DIVIDED_DIFFERENCE_INTERP_ASSERT_SVH
`ifndef SYNTHESIS
`define NDD_ASSERT(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`define NDD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define NDD_ASSERT(lbl, clk, rst, cond)
`define NDD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/ndd_pkg.sv */
// Shared types, constants and saturation helper for the Newton interpolation core.
package ndd_pkg;

  localparam int X_W     = 32;
  localparam int C_W     = 48;
  localparam int DX_W    = 33;
  localparam int DVD_W   = 65;
  localparam int DIV_STEPS = 65;
  localparam int STEP_W  = 7;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_MANY = 2'd2;
  localparam logic [1:0] ST_SAT  = 2'd3;

  // Per-cycle commands broadcast along the cell chain.
  typedef struct packed {
    logic load;
    logic xs_shift;
    logic div_start;
    logic div_step;
    logic div_done;
    logic shift_up;
  } ndd_ctrl_t;

  // Per-cell flags back to the sequencer.
  typedef struct packed {
    logic dx_zero;
    logic sat;
  } ndd_cstat_t;

  // Magnitude plus sign to 48-bit signed, saturating. Returns {sat, value}.
  function automatic logic [C_W:0] sat_from_mag(input logic [DVD_W-1:0] mag,
                                                input logic neg);
    logic [C_W:0] r;
    if (neg) begin
      if ((|mag[DVD_W-1:C_W]) || (mag[C_W-1] && (|mag[C_W-2:0]))) begin
        r = {1'b1, 1'b1, {(C_W-1){1'b0}}};
      end else begin
        r = {1'b0, C_W'(-mag[C_W-1:0])};
      end
    end else begin
      if (|mag[DVD_W-1:C_W-1]) begin
        r = {1'b1, 1'b0, {(C_W-1){1'b1}}};
      end else begin
        r = {1'b0, mag[C_W-1:0]};
      end
    end
    return r;
  endfunction

endpackage

/* rtl/core/newton_divided_difference_interp.sv */
// Top level: Newton divided-difference interpolator over a chain of point cells.
//
// Points (x, y) stream in one per cycle on the slave side while the block is
// idle and land in a chain of MAX_POINTS cells. The transaction with tlast set
// starts the work: each column of divided differences runs in all cells at
// once, one bit-serial divider per cell (n-1 columns for n points). The chain
// then shifts upward so the top cell presents each coefficient in turn to the
// Horner datapath, built from two 33x24 partial products, which runs the
// nested evaluation at query_x. Non-last points are taken even while a result
// waits on the master side. The result carries the saturated Q16.16 value in
// tdata and a status code in tuser: ok, duplicate x, too many points (value
// 0), saturated. The user must write query_x through cfg_we/cfg_wdata only
// while the block is idle; the block itself does not enforce it.
`include "newton_divided_difference_interp_assert.svh"
module newton_divided_difference_interp #(
  parameter int MAX_POINTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] x_value, [63:32] y_value
  input  logic        s_tlast,   // last_point
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] value
  output logic [1:0]  m_tuser,   // [1:0] status
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata  // query_x
);

  localparam int CW = $clog2(MAX_POINTS + 2);
  localparam int XW = ndd_pkg::X_W;
  localparam int CCW = ndd_pkg::C_W;
  localparam int TOP = MAX_POINTS - 1;

  typedef enum logic [3:0] {
    S_IDLE, S_XS, S_CHK, S_DIV, S_WR, S_ALIGN, S_HSH,
    S_M0, S_M1, S_M2, S_M3, S_M4, S_FIN, S_OUT
  } state_t;

  state_t state;
  logic signed [XW-1:0]  query_x;
  logic [CW-1:0]         count;
  logic [CW-1:0]         col;
  logic [CW-1:0]         k;
  logic [CW-1:0]         sh;
  logic [ndd_pkg::STEP_W-1:0] stepc;
  logic                  ovf;
  logic signed [CCW-1:0] acc;
  logic [ndd_pkg::DX_W-1:0] dm;
  logic [CCW-1:0]        am;
  logic                  mneg;
  logic [ndd_pkg::DX_W+23:0] p_lo;
  logic [ndd_pkg::DX_W+23:0] p_hi;
  logic signed [CCW-1:0] mq;
  logic signed [XW-1:0]  res_val;
  logic [1:0]            res_stat;

  ndd_pkg::ndd_ctrl_t    ctrl;
  logic [CW-1:0]         next_cnt;
  logic                  any_zero;
  logic                  any_sat;
  logic signed [ndd_pkg::DX_W-1:0] d;
  logic [80:0]           prod;
  logic [CCW:0]          msat;
  logic signed [CCW:0]   hsum;
  logic                  hsat;
  logic signed [CCW-1:0] hclamp;
  logic                  accept;

  logic signed [XW-1:0]  x_o  [MAX_POINTS];
  logic signed [CCW-1:0] c_o  [MAX_POINTS];
  logic signed [XW-1:0]  xs_o [MAX_POINTS];
  ndd_pkg::ndd_cstat_t   st_o [MAX_POINTS];
  logic [MAX_POINTS-1:0] zero_v;
  logic [MAX_POINTS-1:0] sat_v;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign next_cnt = (count < CW'(MAX_POINTS)) ? count + 1'b1 : CW'(MAX_POINTS + 1);

  // Chain of cells; cell 0 sees zeros from below.
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    logic hit;
    logic act;
    assign hit = (count == CW'(i));
    assign act = (CW'(i) >= col) && (CW'(i) < count);
    if (i == 0) begin : g_first
      ndd_cell u_cell (
        .clk(clk), .ctrl(ctrl), .load_hit(hit), .active(act),
        .x_in(s_tdata[31:0]), .y_in(s_tdata[63:32]),
        .x_prev('0), .c_prev('0), .xs_prev('0),
        .x(x_o[i]), .c(c_o[i]), .xs(xs_o[i]), .stat(st_o[i])
      );
    end else begin : g_rest
      ndd_cell u_cell (
        .clk(clk), .ctrl(ctrl), .load_hit(hit), .active(act),
        .x_in(s_tdata[31:0]), .y_in(s_tdata[63:32]),
        .x_prev(x_o[i-1]), .c_prev(c_o[i-1]), .xs_prev(xs_o[i-1]),
        .x(x_o[i]), .c(c_o[i]), .xs(xs_o[i]), .stat(st_o[i])
      );
    end
    assign zero_v[i] = st_o[i].dx_zero;
    assign sat_v[i]  = st_o[i].sat;
  end

  assign any_zero = |zero_v;
  assign any_sat  = |sat_v;

  always_comb begin
    ctrl.load      = accept;
    ctrl.xs_shift  = (state == S_XS);
    ctrl.div_start = (state == S_CHK);
    ctrl.div_step  = (state == S_DIV);
    ctrl.div_done  = (state == S_WR);
    ctrl.shift_up  = (state == S_HSH) || ((state == S_ALIGN) && (sh != '0));
  end

  // Horner datapath: product split into two 33x24 partials.
  assign d      = ndd_pkg::DX_W'(query_x) - ndd_pkg::DX_W'(x_o[TOP]);
  assign prod   = {24'b0, p_lo} + {p_hi, 24'b0};
  assign msat   = ndd_pkg::sat_from_mag(prod[80:16], mneg);
  assign hsum   = (CCW+1)'(c_o[TOP]) + (CCW+1)'(mq);
  assign hsat   = hsum[CCW] != hsum[CCW-1];
  assign hclamp = hsat ? {hsum[CCW], {(CCW-1){~hsum[CCW]}}} : hsum[CCW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      query_x  <= '0;
      count    <= '0;
      col      <= '0;
      ovf      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        query_x <= cfg_wdata;
      end
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            count <= next_cnt;
            col   <= CW'(1);
            if (s_tlast) begin
              if (next_cnt > CW'(MAX_POINTS)) begin
                res_val  <= '0;
                res_stat <= ndd_pkg::ST_MANY;
                state    <= S_OUT;
              end else if (next_cnt == CW'(1)) begin
                sh    <= CW'(MAX_POINTS - 1);
                k     <= '0;
                state <= S_ALIGN;
              end else begin
                state <= S_XS;
              end
            end
          end
        end
        S_XS: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (any_zero) begin
            res_val  <= '0;
            res_stat <= ndd_pkg::ST_DUP;
            state    <= S_OUT;
          end else begin
            stepc <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          stepc <= stepc + 1'b1;
          if (stepc == ndd_pkg::STEP_W'(ndd_pkg::DIV_STEPS - 1)) begin
            state <= S_WR;
          end
        end
        S_WR: begin
          if (any_sat) begin
            ovf <= 1'b1;
          end
          col <= col + 1'b1;
          if (col + 1'b1 < count) begin
            state <= S_XS;
          end else begin
            sh    <= CW'(MAX_POINTS) - count;
            k     <= count - 1'b1;
            state <= S_ALIGN;
          end
        end
        S_ALIGN: begin
          if (sh == '0) begin
            acc   <= c_o[TOP];
            state <= (k == '0) ? S_FIN : S_HSH;
          end else begin
            sh <= sh - 1'b1;
          end
        end
        S_HSH: begin
          state <= S_M0;
        end
        S_M0: begin
          dm    <= d[ndd_pkg::DX_W-1] ? ndd_pkg::DX_W'(-d) : d;
          am    <= acc[CCW-1] ? CCW'(-acc) : acc;
          mneg  <= d[ndd_pkg::DX_W-1] ^ acc[CCW-1];
          state <= S_M1;
        end
        S_M1: begin
          p_lo  <= dm * am[23:0];
          state <= S_M2;
        end
        S_M2: begin
          p_hi  <= dm * am[47:24];
          state <= S_M3;
        end
        S_M3: begin
          mq <= msat[CCW-1:0];
          if (msat[CCW]) begin
            ovf <= 1'b1;
          end
          state <= S_M4;
        end
        S_M4: begin
          acc <= hclamp;
          if (hsat) begin
            ovf <= 1'b1;
          end
          k     <= k - 1'b1;
          state <= (k == CW'(1)) ? S_FIN : S_HSH;
        end
        S_FIN: begin
          // Final clamp to the 32-bit range.
          if ((acc[CCW-1:XW-1] != '0) && (acc[CCW-1:XW-1] != '1)) begin
            res_val  <= acc[CCW-1] ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}};
            res_stat <= ndd_pkg::ST_SAT;
          end else begin
            res_val  <= acc[XW-1:0];
            res_stat <= ovf ? ndd_pkg::ST_SAT : ndd_pkg::ST_OK;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res_val;
            m_tuser  <= res_stat;
            count    <= '0;
            col      <= '0;
            ovf      <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `NDD_ASSERT(a_count_range, clk, rst, count <= CW'(MAX_POINTS + 1))
  `NDD_ASSERT_IMP(a_many_zero, clk, rst, m_tvalid && (m_tuser == ndd_pkg::ST_MANY), m_tdata == '0)
  `NDD_ASSERT_IMP(a_dup_zero, clk, rst, m_tvalid && (m_tuser == ndd_pkg::ST_DUP), m_tdata == '0)
  `NDD_ASSERT_IMP(a_busy_no_take, clk, rst, state != S_IDLE, !s_tready)

endmodule

/* rtl/core/ndd_cell.sv */
// One chain cell: a stored point, its difference entry and a bit-serial divider.
module ndd_cell (
  input  logic                                clk,
  input  ndd_pkg::ndd_ctrl_t                  ctrl,
  input  logic                                load_hit,
  input  logic                                active,
  input  logic signed [ndd_pkg::X_W-1:0]      x_in,
  input  logic signed [ndd_pkg::X_W-1:0]      y_in,
  input  logic signed [ndd_pkg::X_W-1:0]      x_prev,
  input  logic signed [ndd_pkg::C_W-1:0]      c_prev,
  input  logic signed [ndd_pkg::X_W-1:0]      xs_prev,
  output logic signed [ndd_pkg::X_W-1:0]      x,
  output logic signed [ndd_pkg::C_W-1:0]      c,
  output logic signed [ndd_pkg::X_W-1:0]      xs,
  output ndd_pkg::ndd_cstat_t                 stat
);

  logic signed [ndd_pkg::DX_W-1:0]  dx;
  logic signed [ndd_pkg::C_W:0]     diff;
  logic [ndd_pkg::DX_W-1:0]         dx_mag;
  logic [ndd_pkg::C_W:0]            diff_mag;
  logic [ndd_pkg::DX_W-1:0]         dvs;
  logic [ndd_pkg::DX_W-1:0]         rem;
  logic [ndd_pkg::DVD_W-1:0]        quo;
  logic                             neg;
  logic [ndd_pkg::DX_W:0]           rem_sh;
  logic [ndd_pkg::DX_W:0]           rem_sub;
  logic [ndd_pkg::C_W:0]            qsat;

  assign dx       = ndd_pkg::DX_W'(x) - ndd_pkg::DX_W'(xs);
  assign diff     = (ndd_pkg::C_W+1)'(c) - (ndd_pkg::C_W+1)'(c_prev);
  assign dx_mag   = dx[ndd_pkg::DX_W-1] ? ndd_pkg::DX_W'(-dx) : dx;
  assign diff_mag = diff[ndd_pkg::C_W] ? (ndd_pkg::C_W+1)'(-diff) : diff;
  assign rem_sh   = {rem, quo[ndd_pkg::DVD_W-1]};
  assign rem_sub  = rem_sh - {1'b0, dvs};
  assign qsat     = ndd_pkg::sat_from_mag(quo, neg);

  assign stat.dx_zero = active && (dx == '0);
  assign stat.sat     = active && qsat[ndd_pkg::C_W];

  always_ff @(posedge clk) begin
    if (ctrl.load && load_hit) begin
      x  <= x_in;
      xs <= x_in;
      c  <= ndd_pkg::C_W'(y_in);
    end else if (ctrl.shift_up) begin
      x <= x_prev;
      c <= c_prev;
    end else begin
      if (ctrl.xs_shift) begin
        xs <= xs_prev;
      end
      if (ctrl.div_done && active) begin
        c <= qsat[ndd_pkg::C_W-1:0];
      end
    end

    if (ctrl.div_start) begin
      dvs <= dx_mag;
      rem <= '0;
      quo <= {diff_mag, 16'b0};
      neg <= diff[ndd_pkg::C_W] ^ dx[ndd_pkg::DX_W-1];
    end else if (ctrl.div_step) begin
      if (rem_sh >= {1'b0, dvs}) begin
        rem <= rem_sub[ndd_pkg::DX_W-1:0];
        quo <= {quo[ndd_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[ndd_pkg::DX_W-1:0];
        quo <= {quo[ndd_pkg::DVD_W-2:0], 1'b0};
      end
    end
  end

endmodule
